### rtl/core/sliding_window_lane_search_macros.svh
// Assertion macros shared by the sliding window lane search RTL.
`ifndef SLIDING_WINDOW_LANE_SEARCH_MACROS_SVH
`define SLIDING_WINDOW_LANE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/swls_pkg.sv
// ----------------------------------------------------------------------------
// swls_pkg
// Types, constants and codes of the sliding window lane search block.
// ----------------------------------------------------------------------------
`default_nettype none

package swls_pkg;

  localparam int COORD_BITS    = 12;
  localparam int COUNT_BITS    = 20;
  localparam int MAX_WINDOWS   = 64;
  localparam int WIN_BITS      = 7;
  localparam int SUM_BITS      = COORD_BITS + COUNT_BITS;
  localparam int MARGIN_BITS   = COORD_BITS - 1;
  localparam int CMD_BITS      = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COUNT_BITS;

  localparam logic [COORD_BITS-1:0]  IMAGE_ROWS_RST    = COORD_BITS'(720);
  localparam logic [WIN_BITS-1:0]    WINDOWS_NUM_RST   = WIN_BITS'(32);
  localparam logic [COORD_BITS-1:0]  WINDOW_HEIGHT_RST = COORD_BITS'(22);
  localparam logic [MARGIN_BITS-1:0] MARGIN_RST        = MARGIN_BITS'(100);
  localparam logic [COUNT_BITS-1:0]  MIN_PIX_RST       = COUNT_BITS'(50);

  localparam logic [COUNT_BITS-1:0] HIT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [WIN_BITS-1:0]   LANE_MIN_CENTROIDS = WIN_BITS'(3);
  localparam logic [WIN_BITS-1:0]   MAX_WIN_CNT = WIN_BITS'(MAX_WINDOWS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_START = 2'd0,
    CMD_POINT = 2'd1,
    CMD_END   = 2'd2
  } swls_cmd_e;

  typedef enum logic {
    KIND_CENTROID = 1'b0,
    KIND_SUMMARY  = 1'b1
  } swls_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_ROWS    = 3'd0,
    CFG_WINDOWS_NUM   = 3'd1,
    CFG_WINDOW_HEIGHT = 3'd2,
    CFG_MARGIN        = 3'd3,
    CFG_MIN_PIX       = 3'd4
  } swls_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CLOSE,
    ST_DIV,
    ST_EMIT,
    ST_SUMMARY
  } swls_state_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [COORD_BITS-1:0] x_base;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } swls_in_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic                  lane_found;
    logic [WIN_BITS-1:0]   centroid_count;
    logic                  last;
  } swls_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_load;
    logic latch_point;
    logic hit_update;
    logic close_miss;
    logic close_hit;
    logic div_start;
    logic push_centroid;
    logic push_summary;
    logic cent_last;
  } swls_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic in_rows;
    logic above_min;
    logic div_busy;
    logic slot_free;
  } swls_stat_t;

endpackage

`default_nettype wire

### rtl/core/swls_div.sv
// ----------------------------------------------------------------------------
// swls_div
// Two-lane restoring divider for the window centroid, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swls_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [swls_pkg::SUM_BITS-1:0]   sum_x_i,
  input  wire logic [swls_pkg::SUM_BITS-1:0]   sum_y_i,
  input  wire logic [swls_pkg::COUNT_BITS-1:0] den_i,
  output logic                                 busy_o,
  output logic [swls_pkg::COORD_BITS-1:0]      quot_x_o,
  output logic [swls_pkg::COORD_BITS-1:0]      quot_y_o
);
  import swls_pkg::*;

  localparam int CNT_BITS = $clog2(COORD_BITS + 1);

  logic [CNT_BITS-1:0]   cnt_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [COUNT_BITS-1:0] rem_x_q, rem_y_q, rem_x_n, rem_y_n;
  logic [COORD_BITS-1:0] low_x_q, low_y_q, low_x_n, low_y_n;

  // One restoring step. The mean of coordinates fits COORD_BITS, so the
  // upper part of the sum starts below the divisor and the remainder never
  // grows past the divisor width.
  function automatic logic [COUNT_BITS+COORD_BITS-1:0] div_step(
    input logic [COUNT_BITS-1:0] rem,
    input logic [COORD_BITS-1:0] low,
    input logic [COUNT_BITS-1:0] den
  );
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;
    logic [COUNT_BITS-1:0] rem_n;
    trial = {rem, low[COORD_BITS-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    rem_n = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    return {rem_n, low[COORD_BITS-2:0], ge};
  endfunction

  assign {rem_x_n, low_x_n} = div_step(rem_x_q, low_x_q, den_q);
  assign {rem_y_n, low_y_n} = div_step(rem_y_q, low_y_q, den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_BITS'(COORD_BITS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q   <= den_i;
      rem_x_q <= sum_x_i[SUM_BITS-1:COORD_BITS];
      rem_y_q <= sum_y_i[SUM_BITS-1:COORD_BITS];
      low_x_q <= sum_x_i[COORD_BITS-1:0];
      low_y_q <= sum_y_i[COORD_BITS-1:0];
    end else if (busy_o) begin
      rem_x_q <= rem_x_n;
      rem_y_q <= rem_y_n;
      low_x_q <= low_x_n;
      low_y_q <= low_y_n;
    end
  end

  assign busy_o   = (cnt_q != '0);
  assign quot_x_o = low_x_q;
  assign quot_y_o = low_y_q;

endmodule

`default_nettype wire

### rtl/core/swls_dp.sv
// ----------------------------------------------------------------------------
// swls_dp
// Datapath: configuration registers, window state, bound checks, divider and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swls_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [swls_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [swls_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire swls_pkg::swls_in_t                 in_data_i,
  input  wire swls_pkg::swls_ctrl_t               cmd_i,
  output swls_pkg::swls_stat_t                    stat_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output swls_pkg::swls_out_t                     out_data_o
);
  import swls_pkg::*;

  `include "sliding_window_lane_search_macros.svh"

  localparam int PROD_BITS = WIN_BITS + 1 + COORD_BITS;
  localparam int BND_BITS  = PROD_BITS + 2;
  localparam int XB_BITS   = COORD_BITS + 2;

  // Configuration registers.
  logic [COORD_BITS-1:0]  image_rows_q, window_height_q;
  logic [WIN_BITS-1:0]    windows_num_q;
  logic [MARGIN_BITS-1:0] margin_q;
  logic [COUNT_BITS-1:0]  min_pix_q;

  // Search state.
  logic [WIN_BITS-1:0]   win_idx_q, win_idx_d;
  logic [COORD_BITS-1:0] center_x_q, center_x_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic [SUM_BITS-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [WIN_BITS-1:0]   miss_q, miss_d, made_q, made_d;
  logic                  done_q, done_d;

  logic [COORD_BITS-1:0] px_q, py_q;

  logic                  out_valid_q;
  swls_out_t             out_q;

  logic [WIN_BITS-1:0]   eff_win, win_inc, miss_inc;
  logic [WIN_BITS:0]     w_ext;
  logic [PROD_BITS-1:0]  prod_hi, prod_lo;
  logic signed [BND_BITS-1:0] hi_s, lo_s, py_s;
  logic signed [XB_BITS-1:0]  cx_s, m_s, px_s, lo_x, hi_x;
  logic                  in_x, hit_ok, slot_free;
  logic                  div_busy;
  logic [COORD_BITS-1:0] quot_x, quot_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q    <= IMAGE_ROWS_RST;
      windows_num_q   <= WINDOWS_NUM_RST;
      window_height_q <= WINDOW_HEIGHT_RST;
      margin_q        <= MARGIN_RST;
      min_pix_q       <= MIN_PIX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_ROWS:    image_rows_q    <= cfg_data_i[COORD_BITS-1:0];
        CFG_WINDOWS_NUM:   windows_num_q   <= cfg_data_i[WIN_BITS-1:0];
        CFG_WINDOW_HEIGHT: window_height_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_MARGIN:        margin_q        <= cfg_data_i[MARGIN_BITS-1:0];
        CFG_MIN_PIX:       min_pix_q       <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_win  = (windows_num_q > MAX_WIN_CNT) ? MAX_WIN_CNT : windows_num_q;
  assign win_inc  = win_idx_q + 1'b1;
  assign miss_inc = miss_q + 1'b1;

  // Row band of the current window: [rows - (w+1)*h, rows - w*h).
  assign w_ext   = {1'b0, win_idx_q};
  assign prod_hi = PROD_BITS'(w_ext) * PROD_BITS'(window_height_q);
  assign prod_lo = prod_hi + PROD_BITS'(window_height_q);
  assign hi_s = $signed({{(BND_BITS-COORD_BITS){1'b0}}, image_rows_q})
              - $signed({{(BND_BITS-PROD_BITS){1'b0}}, prod_hi});
  assign lo_s = $signed({{(BND_BITS-COORD_BITS){1'b0}}, image_rows_q})
              - $signed({{(BND_BITS-PROD_BITS){1'b0}}, prod_lo});
  assign py_s = $signed({{(BND_BITS-COORD_BITS){1'b0}}, py_q});

  // Column band around the current center, compared signed.
  assign cx_s = $signed({{(XB_BITS-COORD_BITS){1'b0}}, center_x_q});
  assign m_s  = $signed({{(XB_BITS-MARGIN_BITS){1'b0}}, margin_q});
  assign px_s = $signed({{(XB_BITS-COORD_BITS){1'b0}}, px_q});
  assign lo_x = cx_s - m_s;
  assign hi_x = cx_s + m_s;
  assign in_x   = (px_s >= lo_x) && (px_s < hi_x);
  assign hit_ok = in_x && (hit_cnt_q != HIT_MAX);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    win_idx_d  = win_idx_q;
    center_x_d = center_x_q;
    hit_cnt_d  = hit_cnt_q;
    sum_x_d    = sum_x_q;
    sum_y_d    = sum_y_q;
    miss_d     = miss_q;
    made_d     = made_q;
    done_d     = done_q;
    if (cmd_i.start_load) begin
      win_idx_d  = '0;
      center_x_d = in_data_i.x_base;
      hit_cnt_d  = '0;
      sum_x_d    = '0;
      sum_y_d    = '0;
      miss_d     = '0;
      made_d     = '0;
      done_d     = (eff_win == '0);
    end
    if (cmd_i.hit_update && hit_ok) begin
      hit_cnt_d = hit_cnt_q + 1'b1;
      sum_x_d   = sum_x_q + SUM_BITS'(px_q);
      sum_y_d   = sum_y_q + SUM_BITS'(py_q);
    end
    if (cmd_i.close_miss || cmd_i.close_hit) begin
      hit_cnt_d = '0;
      sum_x_d   = '0;
      sum_y_d   = '0;
      win_idx_d = win_inc;
      if (win_inc >= eff_win) begin
        done_d = 1'b1;
      end
    end
    if (cmd_i.close_miss) begin
      miss_d = miss_inc;
      if (miss_inc == (eff_win >> 2)) begin
        done_d = 1'b1;
      end
    end
    if (cmd_i.close_hit) begin
      center_x_d = quot_x;
      miss_d     = '0;
      made_d     = made_q + 1'b1;
    end
    if (cmd_i.push_summary) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_idx_q  <= '0;
      center_x_q <= '0;
      hit_cnt_q  <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      miss_q     <= '0;
      made_q     <= '0;
      done_q     <= 1'b1;
    end else begin
      win_idx_q  <= win_idx_d;
      center_x_q <= center_x_d;
      hit_cnt_q  <= hit_cnt_d;
      sum_x_q    <= sum_x_d;
      sum_y_q    <= sum_y_d;
      miss_q     <= miss_d;
      made_q     <= made_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_point) begin
      px_q <= in_data_i.px;
      py_q <= in_data_i.py;
    end
  end

  swls_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .sum_x_i  (sum_x_q),
    .sum_y_i  (sum_y_q),
    .den_i    (hit_cnt_q),
    .busy_o   (div_busy),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_centroid || cmd_i.push_summary) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_centroid) begin
      out_q.kind           <= KIND_CENTROID;
      out_q.cx             <= quot_x;
      out_q.cy             <= quot_y;
      out_q.lane_found     <= 1'b0;
      out_q.centroid_count <= '0;
      out_q.last           <= cmd_i.cent_last;
    end else if (cmd_i.push_summary) begin
      out_q.kind           <= KIND_SUMMARY;
      out_q.cx             <= '0;
      out_q.cy             <= '0;
      out_q.lane_found     <= (made_q > LANE_MIN_CENTROIDS);
      out_q.centroid_count <= made_q;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.done      = done_q;
  assign stat_o.in_rows   = (py_s >= lo_s) && (py_s < hi_s);
  assign stat_o.above_min = (hit_cnt_q > min_pix_q);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.slot_free = slot_free;

  `SWLS_ASSERT_IMPL(a_push_after_div, clk_i, rst_ni, cmd_i.push_centroid, !div_busy,
                    "centroid pushed while the divider is still running")

endmodule

`default_nettype wire

### rtl/core/swls_ctrl.sv
// ----------------------------------------------------------------------------
// swls_ctrl
// Controller: decodes each request and steps the datapath through window
// evaluation, closing, division and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module swls_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [swls_pkg::CMD_BITS-1:0] command_i,
  output logic                               in_stall_o,
  input  wire swls_pkg::swls_stat_t          stat_i,
  output swls_pkg::swls_ctrl_t               cmd_o
);
  import swls_pkg::*;

  `include "sliding_window_lane_search_macros.svh"

  swls_state_e state_q, state_d;
  logic        is_end_q, is_end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      is_end_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_end_q <= is_end_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    is_end_d   = is_end_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (command_i)
            CMD_START: begin
              cmd_o.start_load = 1'b1;
            end
            CMD_POINT: begin
              cmd_o.latch_point = 1'b1;
              is_end_d = 1'b0;
              if (!stat_i.done) begin
                state_d = ST_EVAL;
              end
            end
            CMD_END: begin
              is_end_d = 1'b1;
              state_d  = stat_i.done ? ST_SUMMARY : ST_CLOSE;
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (stat_i.done) begin
          state_d = ST_IDLE;
        end else if (stat_i.in_rows) begin
          cmd_o.hit_update = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (stat_i.above_min) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.close_miss = 1'b1;
          state_d = is_end_q ? ST_SUMMARY : ST_EVAL;
        end
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.push_centroid = 1'b1;
          cmd_o.close_hit     = 1'b1;
          // On an end request the summary still follows the centroid.
          cmd_o.cent_last     = !is_end_q;
          state_d = is_end_q ? ST_SUMMARY : ST_EVAL;
        end
      end
      ST_SUMMARY: begin
        if (stat_i.slot_free) begin
          cmd_o.push_summary = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SWLS_ASSERT_IMPL(a_emit_has_hits, clk_i, rst_ni, state_q == ST_EMIT, stat_i.above_min,
                    "centroid delivery without enough hits in the window")
  `SWLS_ASSERT_IMPL(a_eval_entry_live, clk_i, rst_ni,
                    (state_q == ST_EVAL) && ($past(state_q) == ST_IDLE), !stat_i.done,
                    "point evaluation started on a finished search")
  `SWLS_ASSERT_NEXT(a_summary_ends_search, clk_i, rst_ni,
                    (state_q == ST_SUMMARY) && stat_i.slot_free,
                    stat_i.done && (state_q == ST_IDLE),
                    "search still active after the summary was delivered")

endmodule

`default_nettype wire

### rtl/core/sliding_window_lane_search.sv
// ----------------------------------------------------------------------------
// sliding_window_lane_search
// Sliding-window lane pixel search over a stream of set pixel coordinates.
// ----------------------------------------------------------------------------
// Usage: a start request loads the base column. Point requests then carry set
// pixels bottom row first; each window closes when a point lies above it and
// yields a centroid result when it held more than min_pix hits. An end request
// closes the open window and yields a summary (centroid count, lane found).
// Channels: input and output use valid/stall, configuration uses valid/ready
// and is always ready; registers are to be written by the user only while
// the block is idle, which the block does not enforce. Sequence: a point in
// the window is checked against the row band and counted. A window that a
// point closes empty is closed and the point tested again; a window with a
// centroid is closed, divided in the shared two-lane divider (12 quotient
// bits, one per cycle, then seen to finish), sent to the output register,
// and the point tested again. An end closes the open window and then yields
// the summary. The input stalls while a request is in progress.
// Reset loads the register defaults and leaves the search idle until a start.
// When the receiver stalls, the result waits in the output register; the next
// request is still taken, and the block only waits if it has another result.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_lane_search (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [swls_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [swls_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire swls_pkg::swls_in_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output swls_pkg::swls_out_t                     out_data_o
);
  import swls_pkg::*;

  swls_ctrl_t ctrl_cmd;
  swls_stat_t dp_stat;

  swls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_data_i.command),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  swls_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
